// ===== hw/rtl/csc_pkg.sv =====
// Shared types, constants and reset values of the current sample conditioner.
package csc_pkg;

  // Default build parameters
  localparam int DEFAULT_ADC_BITS   = 12;
  localparam int DEFAULT_HIST_DEPTH = 256;

  // Port field widths
  localparam int CODE_W     = 12;
  localparam int STAMP_W    = 32;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 200;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Current limits in milliamps
  localparam int LIM_MA   = 40000;
  localparam int RANGE_MA = 35000;

  // Register reset values
  localparam logic [11:0] ZERO_CODE_RST = 12'd2048;
  localparam logic [15:0] GAIN_RST      = 16'd3124;
  localparam logic [15:0] OFFSET_RST    = 16'd0;
  localparam logic [15:0] ALPHA_RST     = 16'd6554;
  localparam logic [15:0] SPIKE_RST     = 16'd300;
  localparam logic [11:0] WIN_A_RST     = 12'd10;
  localparam logic [11:0] WIN_B_RST     = 12'd60;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_CODE = 3'd0,
    CFG_GAIN      = 3'd1,
    CFG_OFFSET    = 3'd2,
    CFG_ALPHA     = 3'd3,
    CFG_SPIKE     = 3'd4,
    CFG_WIN_A     = 3'd5,
    CFG_WIN_B     = 3'd6
  } cfg_idx_t;

  // Datapath commands, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_CUR,
    OP_CUR,
    OP_MUL_NEW,
    OP_MUL_OLD,
    OP_SMOOTH,
    OP_SNAP,
    OP_PEAK,
    OP_HIST_WR,
    OP_DROP_RD,
    OP_DROP_EV,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_OUT
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic fault;
    logic fill_zero;
    logic drop_need;
    logic scan_done;
    logic out_free;
  } dp_status_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BRANCH,
    ST_CUR,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_SMOOTH,
    ST_SNAP,
    ST_PEAK,
    ST_HIST,
    ST_DROP_RD,
    ST_DROP_EV,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_OUT
  } ctrl_state_t;

  // Saturating counter step
  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

// ===== hw/rtl/csc_ctrl.sv =====
// Sequencer that steps the conditioner datapath through one sample.
module csc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  csc_pkg::dp_status_t status,
  output csc_pkg::dp_op_t     op
);

  csc_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    op        = csc_pkg::OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      csc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op        = csc_pkg::OP_LOAD;
          state_nxt = csc_pkg::ST_BRANCH;
        end
      end
      csc_pkg::ST_BRANCH: begin
        if (status.fault) begin
          op        = csc_pkg::OP_SCAN_INIT;
          state_nxt = csc_pkg::ST_SCAN;
        end else begin
          op        = csc_pkg::OP_MUL_CUR;
          state_nxt = csc_pkg::ST_CUR;
        end
      end
      csc_pkg::ST_CUR: begin
        op        = csc_pkg::OP_CUR;
        state_nxt = csc_pkg::ST_MUL_NEW;
      end
      csc_pkg::ST_MUL_NEW: begin
        op        = csc_pkg::OP_MUL_NEW;
        state_nxt = csc_pkg::ST_MUL_OLD;
      end
      csc_pkg::ST_MUL_OLD: begin
        op        = csc_pkg::OP_MUL_OLD;
        state_nxt = csc_pkg::ST_SMOOTH;
      end
      csc_pkg::ST_SMOOTH: begin
        op        = csc_pkg::OP_SMOOTH;
        state_nxt = csc_pkg::ST_SNAP;
      end
      csc_pkg::ST_SNAP: begin
        op        = csc_pkg::OP_SNAP;
        state_nxt = csc_pkg::ST_PEAK;
      end
      csc_pkg::ST_PEAK: begin
        op        = csc_pkg::OP_PEAK;
        state_nxt = csc_pkg::ST_HIST;
      end
      csc_pkg::ST_HIST: begin
        op        = csc_pkg::OP_HIST_WR;
        state_nxt = csc_pkg::ST_DROP_RD;
      end
      csc_pkg::ST_DROP_RD: begin
        if (status.fill_zero) begin
          op        = csc_pkg::OP_SCAN_INIT;
          state_nxt = csc_pkg::ST_SCAN;
        end else begin
          op        = csc_pkg::OP_DROP_RD;
          state_nxt = csc_pkg::ST_DROP_EV;
        end
      end
      csc_pkg::ST_DROP_EV: begin
        op        = csc_pkg::OP_DROP_EV;
        state_nxt = status.drop_need ? csc_pkg::ST_DROP_RD : csc_pkg::ST_SCAN_INIT;
      end
      csc_pkg::ST_SCAN_INIT: begin
        op        = csc_pkg::OP_SCAN_INIT;
        state_nxt = csc_pkg::ST_SCAN;
      end
      csc_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = csc_pkg::ST_OUT;
        end else begin
          op = csc_pkg::OP_SCAN;
        end
      end
      csc_pkg::ST_OUT: begin
        if (status.out_free) begin
          op        = csc_pkg::OP_OUT;
          state_nxt = csc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/csc_dp.sv =====
// Datapath of the conditioner: registers, multiplier, history memory, result register.
module csc_dp #(
  parameter int ADC_BITS   = csc_pkg::DEFAULT_ADC_BITS,
  parameter int HIST_DEPTH = csc_pkg::DEFAULT_HIST_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [csc_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [csc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  csc_pkg::dp_op_t                    op,
  output csc_pkg::dp_status_t                status,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [csc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tuser
);

  localparam int PW = $clog2(HIST_DEPTH);
  localparam int FW = $clog2(HIST_DEPTH + 1);
  localparam logic [11:0] CODE_MASK =
    (ADC_BITS >= 12) ? 12'hFFF : 12'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [FW:0] DEPTH_W = (FW + 1)'(HIST_DEPTH);

  // Configuration registers
  logic [11:0] zero_r, win_a_r, win_b_r;
  logic [15:0] gain_r, offset_r, alpha_r, spike_r;

  // Sample registers
  logic        fault_r;
  logic [11:0] code_r;
  logic [31:0] now_r;

  // Arithmetic registers
  logic signed [51:0] prod_r, mnew_r;
  logic signed [16:0] cur_r;
  logic               ok_r;
  logic signed [32:0] acc_r;

  // Tracking state
  logic [15:0]          peak_abs_r;
  logic signed [16:0]   peak_sgn_r;
  logic [31:0]          prev_r;
  logic                 have_prev_r;
  logic [31:0]          samples_r, repeats_r, faults_r;
  logic [PW-1:0]        head_r;
  logic [FW-1:0]        fill_r;

  // History memory and its read port
  logic [31:0] mem_stamp [HIST_DEPTH];
  logic [15:0] mem_mag   [HIST_DEPTH];
  logic [31:0] rd_stamp_r;
  logic [15:0] rd_mag_r;
  logic [PW-1:0] rd_addr;

  // Scan state
  logic [PW-1:0] sptr_r;
  logic [FW-1:0] k_r;
  logic          v_r;
  logic [15:0]   best_a_r, best_b_r;

  // Result register
  logic                         out_valid_r;
  logic [csc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                         out_user_r;

  // Shared multiplier
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_p;
  logic signed [12:0] diff;

  assign diff  = $signed({1'b0, code_r & CODE_MASK}) - $signed({1'b0, zero_r});
  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (op)
      csc_pkg::OP_MUL_CUR: begin
        mul_a = 34'(diff);
        mul_b = $signed({2'b00, gain_r});
      end
      csc_pkg::OP_MUL_NEW: begin
        mul_a = 34'(cur_r);
        mul_b = $signed({2'b00, alpha_r});
      end
      csc_pkg::OP_MUL_OLD: begin
        mul_a = 34'(acc_r);
        mul_b = $signed({1'b0, 17'h10000 - {1'b0, alpha_r}});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round, offset and saturate the converted current
  logic signed [33:0] rnd;
  logic signed [34:0] cur_full;
  logic signed [16:0] cur_sat;
  logic               cur_ok;

  always_comb begin
    rnd      = ($signed(prod_r[33:0]) + 34'sd128) >>> 8;
    cur_full = 35'(rnd) + 35'($signed(offset_r));
    if (cur_full > 35'sd40000) begin
      cur_sat = 17'(csc_pkg::LIM_MA);
    end else if (cur_full < -35'sd40000) begin
      cur_sat = -17'(csc_pkg::LIM_MA);
    end else begin
      cur_sat = cur_full[16:0];
    end
    cur_ok = (cur_sat >= -17'sd35000) && (cur_sat <= 17'sd35000);
  end

  // Average update and spike test
  logic signed [51:0] t_sum;
  logic signed [33:0] cur_q;
  logic signed [34:0] dev;
  logic [34:0]        dev_abs;

  always_comb begin
    t_sum   = (mnew_r <<< 16) + prod_r;
    cur_q   = 34'(cur_r) <<< 16;
    dev     = 35'(acc_r) - 35'(cur_q);
    dev_abs = dev[34] ? 35'(-dev) : 35'(dev);
  end

  // Smoothed value truncated toward zero and its magnitude
  logic [33:0]        acc_neg;
  logic signed [16:0] smooth;
  logic [15:0]        mag;

  always_comb begin
    acc_neg = 34'(-35'(acc_r));
    if (acc_r[32]) begin
      smooth = -17'(acc_neg[33:16]);
      mag    = acc_neg[31:16];
    end else begin
      smooth = acc_r[32:16];
      mag    = acc_r[31:16];
    end
  end

  // History pointers
  logic [FW:0]   slot_sum;
  logic [PW-1:0] slot;
  logic [PW-1:0] head_inc, sptr_inc;
  logic          hist_full;

  always_comb begin
    slot_sum  = (FW + 1)'(head_r) + (FW + 1)'(fill_r);
    slot      = (slot_sum >= DEPTH_W) ? PW'(slot_sum - DEPTH_W) : PW'(slot_sum);
    head_inc  = (head_r == PW'(HIST_DEPTH - 1)) ? '0 : head_r + PW'(1);
    sptr_inc  = (sptr_r == PW'(HIST_DEPTH - 1)) ? '0 : sptr_r + PW'(1);
    hist_full = (fill_r == FW'(HIST_DEPTH));
    rd_addr   = (op == csc_pkg::OP_SCAN) ? sptr_r : head_r;
  end

  // Window spans and ages
  logic [21:0] span_a, span_b;
  logic [31:0] age;
  logic        drop_need;

  always_comb begin
    span_a    = 22'(win_a_r) * 22'd1000;
    span_b    = 22'(win_b_r) * 22'd1000;
    age       = now_r - rd_stamp_r;
    drop_need = age > {10'b0, span_b};
  end

  // Status to the controller
  assign status.fault     = fault_r;
  assign status.fill_zero = (fill_r == '0);
  assign status.drop_need = drop_need;
  assign status.scan_done = (k_r == fill_r) && !v_r;
  assign status.out_free  = !out_valid_r || out_tready;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r   <= csc_pkg::ZERO_CODE_RST;
      gain_r   <= csc_pkg::GAIN_RST;
      offset_r <= csc_pkg::OFFSET_RST;
      alpha_r  <= csc_pkg::ALPHA_RST;
      spike_r  <= csc_pkg::SPIKE_RST;
      win_a_r  <= csc_pkg::WIN_A_RST;
      win_b_r  <= csc_pkg::WIN_B_RST;
    end else if (cfg_valid) begin
      case (csc_pkg::cfg_idx_t'(cfg_index))
        csc_pkg::CFG_ZERO_CODE: zero_r   <= cfg_data[11:0];
        csc_pkg::CFG_GAIN:      gain_r   <= cfg_data;
        csc_pkg::CFG_OFFSET:    offset_r <= cfg_data;
        csc_pkg::CFG_ALPHA:     alpha_r  <= cfg_data;
        csc_pkg::CFG_SPIKE:     spike_r  <= cfg_data;
        csc_pkg::CFG_WIN_A:     win_a_r  <= cfg_data[11:0];
        csc_pkg::CFG_WIN_B:     win_b_r  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (op)
      csc_pkg::OP_LOAD: begin
        fault_r <= in_tuser;
        code_r  <= in_tdata[11:0];
        now_r   <= in_tdata[43:12];
        cur_r   <= '0;
        ok_r    <= 1'b0;
      end
      csc_pkg::OP_MUL_CUR, csc_pkg::OP_MUL_NEW: begin
        prod_r <= mul_p;
      end
      csc_pkg::OP_MUL_OLD: begin
        mnew_r <= prod_r;
        prod_r <= mul_p;
      end
      csc_pkg::OP_CUR: begin
        cur_r <= cur_sat;
        ok_r  <= cur_ok;
      end
      default: ;
    endcase
  end

  // Sample tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      peak_abs_r  <= '0;
      peak_sgn_r  <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      samples_r   <= '0;
      repeats_r   <= '0;
      faults_r    <= '0;
      head_r      <= '0;
      fill_r      <= '0;
    end else begin
      case (op)
        csc_pkg::OP_LOAD: begin
          samples_r <= csc_pkg::sat_inc(samples_r);
          if (in_tuser) begin
            faults_r <= csc_pkg::sat_inc(faults_r);
          end
        end
        csc_pkg::OP_CUR: begin
          if (have_prev_r && now_r == prev_r) begin
            repeats_r <= csc_pkg::sat_inc(repeats_r);
          end
          prev_r      <= now_r;
          have_prev_r <= 1'b1;
        end
        csc_pkg::OP_SMOOTH: begin
          acc_r <= 33'(t_sum >>> 16);
        end
        csc_pkg::OP_SNAP: begin
          if (dev_abs > {3'b0, spike_r, 16'b0}) begin
            acc_r <= 33'(cur_q);
          end
        end
        csc_pkg::OP_PEAK: begin
          if (mag > peak_abs_r) begin
            peak_abs_r <= mag;
            peak_sgn_r <= smooth;
          end
        end
        csc_pkg::OP_HIST_WR: begin
          if (hist_full) begin
            head_r <= head_inc;
          end else begin
            fill_r <= fill_r + FW'(1);
          end
        end
        csc_pkg::OP_DROP_EV: begin
          if (drop_need) begin
            head_r <= head_inc;
            fill_r <= fill_r - FW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // History memory
  always_ff @(posedge clk) begin
    if (op == csc_pkg::OP_HIST_WR) begin
      mem_stamp[hist_full ? head_r : slot] <= now_r;
      mem_mag[hist_full ? head_r : slot]   <= mag;
    end
    rd_stamp_r <= mem_stamp[rd_addr];
    rd_mag_r   <= mem_mag[rd_addr];
  end

  // Window scan: issue one read a cycle, evaluate it the next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      k_r <= '0;
    end else if (op == csc_pkg::OP_SCAN_INIT) begin
      sptr_r   <= head_r;
      k_r      <= '0;
      v_r      <= 1'b0;
      best_a_r <= '0;
      best_b_r <= '0;
    end else if (op == csc_pkg::OP_SCAN) begin
      if (k_r != fill_r) begin
        k_r    <= k_r + FW'(1);
        sptr_r <= sptr_inc;
        v_r    <= 1'b1;
      end else begin
        v_r <= 1'b0;
      end
      if (v_r) begin
        if (age <= {10'b0, span_a} && rd_mag_r > best_a_r) begin
          best_a_r <= rd_mag_r;
        end
        if (age <= {10'b0, span_b} && rd_mag_r > best_b_r) begin
          best_b_r <= rd_mag_r;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == csc_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == csc_pkg::OP_OUT) begin
      out_user_r <= ok_r;
      out_data_r <= {5'b0, faults_r, repeats_r, samples_r, best_b_r, best_a_r,
                     peak_sgn_r, peak_abs_r, smooth, cur_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(HIST_DEPTH))
    else $error("history fill above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= PW'(HIST_DEPTH - 1))
    else $error("history head out of range");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    op == csc_pkg::OP_OUT |=> out_valid_r)
    else $error("result not presented after load");

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    op == csc_pkg::OP_SCAN |-> k_r <= fill_r)
    else $error("scan ran past history fill");

endmodule

// ===== hw/rtl/current_sample_conditioner.sv =====
// Top level of the current sample conditioner.
// Usage:
//  in_*  : one ADC sample per transaction; in_tuser = adc_fault,
//          in_tdata = adc_code [11:0], time_ms [43:12].
//  out_* : one result transaction per sample; out_tuser = in_range.
//  cfg_* : register writes (index, data), always ready; write only while idle.
// Sequencing: a faulted sample goes straight to the window scan; a good sample
//  first runs conversion, averaging, peak, history write and the aging checks
//  on the oldest entries (each a registered read, then a compare). The scan
//  reads every filled entry, one per cycle (one shared read port). One sample
//  is in work at a time.
// Reset (rst_n low, synchronous) loads the register defaults and clears the
//  average, peaks, counters and history pointers; the history memory itself
//  is not cleared, entries are only read after being written.
// When the receiver stalls, the result holds in the output register; the
//  next sample is still taken and processed, and waits to deliver until the
//  output register has been emptied.
module current_sample_conditioner #(
  parameter int ADC_BITS   = csc_pkg::DEFAULT_ADC_BITS,
  parameter int HIST_DEPTH = csc_pkg::DEFAULT_HIST_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // adc_code [11:0], time_ms [43:12], zero fill [47:44]
  input  logic [csc_pkg::IN_DATA_W-1:0]  in_tdata,
  // adc_fault [0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // current_ma [16:0], smooth_ma [33:17], peak_abs_ma [49:34],
  // peak_signed_ma [66:50], window_a_peak_ma [82:67], window_b_peak_ma [98:83],
  // sample_count [130:99], repeat_count [162:131], fault_count [194:163]
  output logic [csc_pkg::OUT_DATA_W-1:0] out_tdata,
  // in_range [0]
  output logic                           out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [csc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csc_pkg::CFG_DATA_W-1:0] cfg_data
);

  csc_pkg::dp_op_t     op;
  csc_pkg::dp_status_t status;

  // Sequencer
  csc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .op        (op)
  );

  // Datapath
  csc_dp #(
    .ADC_BITS   (ADC_BITS),
    .HIST_DEPTH (HIST_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== dv/current_sample_conditioner_test.sv =====
// Testbench for the current sample conditioner: directed rows, then randomized phases.
`timescale 1ns / 100ps

module current_sample_conditioner_test;

  // One result transaction, unpacked
  typedef struct {
    bit [16:0] cur;
    bit [16:0] smooth;
    bit        rng;
    bit [15:0] pk_abs;
    bit [16:0] pk_sgn;
    bit [15:0] win_a;
    bit [15:0] win_b;
    bit [31:0] n_samp;
    bit [31:0] n_rep;
    bit [31:0] n_fault;
  } reading_t;

  // Directed row: either a register write or a sample
  typedef struct {
    bit                 is_cfg;
    csc_pkg::cfg_idx_t  idx;
    bit [15:0]          val;
    bit                 fault;
    bit [11:0]          code;
    bit [31:0]          stamp;
    bit                 chk;
    int                 exp_cur;
    bit                 exp_rng;
  } row_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [csc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [csc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [csc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [csc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  current_sample_conditioner u_top (.*);

  // Conditioner state as the testbench tracks it
  int        zero_r = 2048, gain_r = 3124, offset_r = 0;
  longint    alpha_r = 6554, spike_r = 300;
  bit [31:0] wina_r = 10, winb_r = 60;
  longint    avg_acc = 0;
  longint    peak_mag = 0, peak_val = 0;
  bit [31:0] hist_t[256];
  bit [15:0] hist_m[256];
  int        hist_head = 0, hist_fill = 0;
  bit [31:0] last_stamp = 0;
  bit        seen_good = 0;
  bit [31:0] samp_cnt = 0, rep_cnt = 0, fault_cnt = 0;

  reading_t  pending_results[$];
  int        acc_cnt = 0, cfg_cnt = 0, err_cnt = 0;
  int        snd_idle = 11, rcv_idle = 48;
  bit        hold_req = 0, hold_on = 0;
  bit        typed_chk = 0, typed_rng = 0;
  int        typed_cur = 0;
  bit [31:0] stamp_now = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [31:0] bump(input bit [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // Largest magnitude among history entries no older than the window
  function automatic bit [15:0] window_max(input bit [31:0] now, input bit [31:0] win);
    bit [31:0] span;
    bit [15:0] best;
    int        i;
    span = win * 32'd1000;
    best = 0;
    for (int k = 0; k < hist_fill; k++) begin
      i = (hist_head + k) % 256;
      if (now - hist_t[i] <= span && hist_m[i] > best) best = hist_m[i];
    end
    return best;
  endfunction

  // Advance the tracked state by one sample and form its result
  function automatic reading_t condition_sample(input bit f, input bit [11:0] code,
                                                input bit [31:0] now);
    longint   p, cur, t, dev, sm, mag;
    int       slot;
    reading_t r;
    cur = 0;
    samp_cnt = bump(samp_cnt);
    if (f) begin
      fault_cnt = bump(fault_cnt);
    end else begin
      p = (longint'(code) - longint'(zero_r)) * longint'(gain_r);
      cur = ((p + 128) >>> 8) + longint'(offset_r);
      if (cur > csc_pkg::LIM_MA) cur = csc_pkg::LIM_MA;
      if (cur < -csc_pkg::LIM_MA) cur = -csc_pkg::LIM_MA;
      if (seen_good && now == last_stamp) rep_cnt = bump(rep_cnt);
      last_stamp = now;
      seen_good = 1;
      // average, then snap to the raw value on a spike
      t = alpha_r * (cur * 65536) + (65536 - alpha_r) * avg_acc;
      avg_acc = t >>> 16;
      dev = avg_acc - cur * 65536;
      if (dev < 0) dev = -dev;
      if (dev > spike_r * 65536) avg_acc = cur * 65536;
      sm = avg_acc / 65536;
      mag = (sm < 0) ? -sm : sm;
      if (mag > peak_mag) begin
        peak_mag = mag;
        peak_val = sm;
      end
      // append to history, overwriting the oldest when full
      if (hist_fill < 256) begin
        slot = (hist_head + hist_fill) % 256;
        hist_fill++;
      end else begin
        slot = hist_head;
        hist_head = (hist_head + 1) % 256;
      end
      hist_t[slot] = now;
      hist_m[slot] = mag[15:0];
      // drop stale entries from the front
      while (hist_fill > 0 && now - hist_t[hist_head] > winb_r * 32'd1000) begin
        hist_head = (hist_head + 1) % 256;
        hist_fill--;
      end
    end
    sm = avg_acc / 65536;
    r.cur     = cur[16:0];
    r.smooth  = sm[16:0];
    r.rng     = (!f && cur >= -csc_pkg::RANGE_MA && cur <= csc_pkg::RANGE_MA);
    r.pk_abs  = peak_mag[15:0];
    r.pk_sgn  = peak_val[16:0];
    r.win_a   = window_max(now, wina_r);
    r.win_b   = window_max(now, winb_r);
    r.n_samp  = samp_cnt;
    r.n_rep   = rep_cnt;
    r.n_fault = fault_cnt;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint e, input longint a);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch in %s: expected %0d, got %0d", what, e, a);
  endtask

  task automatic compare_field(input string what, input longint e, input longint a);
    if (e != a) flag_mismatch(what, e, a);
  endtask

  // Sample every handshake at the rising edge
  always @(posedge clk) begin : monitor
    reading_t r, got;
    if (rst_n && in_tvalid && in_tready) begin
      r = condition_sample(in_tuser, in_tdata[11:0], in_tdata[43:12]);
      if (typed_chk) begin
        r.cur = typed_cur[16:0];
        r.rng = typed_rng;
      end
      pending_results.insert(pending_results.size(), r);
      acc_cnt++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (csc_pkg::cfg_idx_t'(cfg_index))
        csc_pkg::CFG_ZERO_CODE: zero_r = cfg_data[11:0];
        csc_pkg::CFG_GAIN:      gain_r = cfg_data;
        csc_pkg::CFG_OFFSET:    offset_r = $signed(cfg_data);
        csc_pkg::CFG_ALPHA:     alpha_r = cfg_data;
        csc_pkg::CFG_SPIKE:     spike_r = cfg_data;
        csc_pkg::CFG_WIN_A:     wina_r = cfg_data[11:0];
        csc_pkg::CFG_WIN_B:     winb_r = cfg_data[11:0];
        default: ;
      endcase
      cfg_cnt++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.cur = out_tdata[16:0];     got.smooth = out_tdata[33:17];
      got.pk_abs = out_tdata[49:34]; got.pk_sgn = out_tdata[66:50];
      got.win_a = out_tdata[82:67];  got.win_b = out_tdata[98:83];
      got.n_samp = out_tdata[130:99]; got.n_rep = out_tdata[162:131];
      got.n_fault = out_tdata[194:163]; got.rng = out_tuser;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, sample_count", -1, got.n_samp);
      end else begin
        r = pending_results[0];
        pending_results.delete(0);
        compare_field("current_ma", r.cur, got.cur);
        compare_field("smooth_ma", r.smooth, got.smooth);
        compare_field("in_range", r.rng, got.rng);
        compare_field("peak_abs_ma", r.pk_abs, got.pk_abs);
        compare_field("peak_signed_ma", r.pk_sgn, got.pk_sgn);
        compare_field("window_a_peak_ma", r.win_a, got.win_a);
        compare_field("window_b_peak_ma", r.win_b, got.win_b);
        compare_field("sample_count", r.n_samp, got.n_samp);
        compare_field("repeat_count", r.n_rep, got.n_rep);
        compare_field("fault_count", r.n_fault, got.n_fault);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_on && ($urandom_range(0, 99) >= rcv_idle);
  end

  // Hold off the receiver for a long stretch
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_on = 1;
        repeat (3000) @(negedge clk);
        hold_on = 0;
        hold_req = 0;
      end
    end
  end

  // Offer one sample and wait until it is taken
  task automatic send_sample(input bit f, input bit [11:0] c, input bit [31:0] s,
                             input bit chk, input int ecur, input bit erng);
    int n;
    n = acc_cnt;
    if ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < snd_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {4'b0, s, c};
    typed_chk = chk;
    typed_cur = ecur;
    typed_rng = erng;
    do @(negedge clk); while (acc_cnt == n);
  endtask

  // Drain all results, then let the block finish its trailing work
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (900) @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input csc_pkg::cfg_idx_t idx, input bit [15:0] v);
    int n;
    n = cfg_cnt;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(negedge clk); while (cfg_cnt == n);
  endtask

  function automatic bit [15:0] pick_window();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 4095))
                                       : 16'($urandom_range(0, 90));
  endfunction

  row_t dir_rows[] = '{
    // defaults: fault, zero code, repeats, spikes, aging, wraparound
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 1, 12'd0,    32'd0,          1, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd2048, 32'd0,          1, 0, 1},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd2048, 32'd0,          0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd4095, 32'd5,          0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd0,    32'd10,         0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd2049, 32'd20,         0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd2050, 32'd30,         0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 1, 12'd4095, 32'd40,         1, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd4095, 32'd40,         0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd2048, 32'd9000,       0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd2048, 32'd10005,      0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd2100, 32'd70040,      0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd1000, 32'hFFFF_FF00,  0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd3000, 32'h0000_0100,  0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'hAAA,  32'hAAAA_AAAA,  0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'h555,  32'h5555_5555,  0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 1, 12'hFFF,  32'hFFFF_FFFF,  1, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd2048, 32'hFFFF_FFFF,  0, 0, 0},
    // negative extremes, zero window A, full window B
    '{1, csc_pkg::CFG_ZERO_CODE, 16'd4095,  0, 0, 0, 0, 0, 0},
    '{1, csc_pkg::CFG_GAIN,      16'hFFFF,  0, 0, 0, 0, 0, 0},
    '{1, csc_pkg::CFG_OFFSET,    16'h8000,  0, 0, 0, 0, 0, 0},
    '{1, csc_pkg::CFG_ALPHA,     16'hFFFF,  0, 0, 0, 0, 0, 0},
    '{1, csc_pkg::CFG_SPIKE,     16'd0,     0, 0, 0, 0, 0, 0},
    '{1, csc_pkg::CFG_WIN_A,     16'd0,     0, 0, 0, 0, 0, 0},
    '{1, csc_pkg::CFG_WIN_B,     16'd4095,  0, 0, 0, 0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd0,    32'd100,        1, -40000, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd4095, 32'd200,        1, -32768, 1},
    // positive extremes
    '{1, csc_pkg::CFG_ZERO_CODE, 16'd0,     0, 0, 0, 0, 0, 0},
    '{1, csc_pkg::CFG_OFFSET,    16'h7FFF,  0, 0, 0, 0, 0, 0},
    '{1, csc_pkg::CFG_ALPHA,     16'd0,     0, 0, 0, 0, 0, 0},
    '{1, csc_pkg::CFG_SPIKE,     16'hFFFF,  0, 0, 0, 0, 0, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd4095, 32'd300,        1, 40000, 0},
    '{0, csc_pkg::CFG_ZERO_CODE, 0, 0, 12'd0,    32'd300,        1, 32767, 1}
  };

  initial begin : stimulus
    int        step_max;
    bit        f;
    bit [11:0] c;
    int        sel;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_block();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
        cfg_valid <= 1'b0;
      end else begin
        send_sample(dir_rows[i].fault, dir_rows[i].code, dir_rows[i].stamp,
                    dir_rows[i].chk, dir_rows[i].exp_cur, dir_rows[i].exp_rng);
      end
    end
    stamp_now = 32'd1000;

    // random phases, each with fresh register settings
    for (int ph = 0; ph < 10; ph++) begin
      drain_block();
      write_reg(csc_pkg::CFG_ZERO_CODE, 16'($urandom_range(0, 4095)));
      write_reg(csc_pkg::CFG_GAIN, 16'($urandom_range(1, 65535)));
      write_reg(csc_pkg::CFG_OFFSET, 16'($urandom));
      write_reg(csc_pkg::CFG_ALPHA, 16'($urandom));
      write_reg(csc_pkg::CFG_SPIKE, ($urandom_range(0, 1) == 0)
                                    ? 16'($urandom_range(0, 2000)) : 16'($urandom));
      write_reg(csc_pkg::CFG_WIN_A, pick_window());
      write_reg(csc_pkg::CFG_WIN_B, pick_window());
      cfg_valid <= 1'b0;

      if (ph < 4) begin
        snd_idle = 11; rcv_idle = 48;
      end else if (ph < 7) begin
        snd_idle = 48; rcv_idle = 11;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      sel = $urandom_range(0, 2);
      step_max = (sel == 0) ? 40 : (sel == 1) ? 2000 : 20000;
      if (ph == 2) hold_req = 1;

      for (int k = 0; k < 188; k++) begin
        // pause the sender until every result is back
        if (ph == 5 && k == 80) begin
          in_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
        f = ($urandom_range(0, 9) == 0);
        c = ($urandom_range(0, 1) == 0) ? 12'($urandom)
                                        : 12'(zero_r + $urandom_range(0, 40) - 20);
        sel = $urandom_range(0, 99);
        if (sel < 4) stamp_now = $urandom;
        else if (sel >= 12) stamp_now = stamp_now + $urandom_range(1, step_max);
        send_sample(f, c, stamp_now, 0, 0, 0);
      end
    end

    drain_block();
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
